// File: rtl/core/dvr_pkg.sv
`timescale 1ns / 1ps

package dvr_pkg;

  localparam int NODE_COUNT = 6;
  localparam int SLOTS      = 6;
  localparam int ENTRY_W    = 3;
  localparam int DIST_W     = 16;
  localparam int HOP_W      = 4;
  localparam int IN_DATA_W  = 104;
  localparam int OUT_DATA_W = 32;
  localparam int ADDR_W     = 5;

  localparam logic [DIST_W-1:0] DIST_MAX  = 16'h7FFF;
  localparam logic [DIST_W-1:0] DIST_NONE = 16'hFFFF;
  localparam logic [HOP_W-1:0]  HOP_NONE  = 4'hF;

  // register indexes (byte address / 4)
  localparam logic [2:0] REG_MY_NODE    = 3'd0;
  localparam logic [2:0] REG_LINK_COST0 = 3'd1;

  // operation codes carried in tuser
  localparam logic OP_INIT  = 1'b0;
  localparam logic OP_APPLY = 1'b1;

  typedef struct packed {
    logic [ENTRY_W-1:0]           my_node;
    logic [SLOTS-1:0][DIST_W-1:0] link_cost;
  } dvr_cfg_t;

  typedef struct packed {
    logic               load;
    logic [ENTRY_W-1:0] idx;
  } dvr_cmd_t;

endpackage

// File: rtl/core/dvr_regs.sv
`timescale 1ns / 1ps

module dvr_regs (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [dvr_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]               pwdata,
  output logic [31:0]               prdata,
  output logic                      pready,
  output dvr_pkg::dvr_cfg_t         cfg_o
);

  logic [dvr_pkg::ENTRY_W-1:0]                   my_node_q;
  logic [dvr_pkg::SLOTS-1:0][dvr_pkg::DIST_W-1:0] link_cost_q;
  logic [2:0]                                    reg_idx;
  logic                                          wr_en;

  assign reg_idx = paddr[4:2];
  assign wr_en   = psel && penable && pwrite;
  assign pready  = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      my_node_q <= '0;
      for (int i = 0; i < dvr_pkg::SLOTS; i++) begin
        link_cost_q[i] <= dvr_pkg::DIST_NONE;
      end
    end else if (wr_en) begin
      if (reg_idx == dvr_pkg::REG_MY_NODE) begin
        my_node_q <= pwdata[dvr_pkg::ENTRY_W-1:0];
      end else begin
        for (int i = 0; i < dvr_pkg::SLOTS; i++) begin
          if (reg_idx == dvr_pkg::REG_LINK_COST0 + 3'(i)) begin
            link_cost_q[i] <= pwdata[dvr_pkg::DIST_W-1:0];
          end
        end
      end
    end
  end

  always_comb begin
    prdata = '0;
    if (reg_idx == dvr_pkg::REG_MY_NODE) begin
      prdata = {29'b0, my_node_q};
    end else begin
      for (int i = 0; i < dvr_pkg::SLOTS; i++) begin
        if (reg_idx == dvr_pkg::REG_LINK_COST0 + 3'(i)) begin
          prdata = {{16{link_cost_q[i][15]}}, link_cost_q[i]};
        end
      end
    end
  end

  assign cfg_o.my_node   = my_node_q;
  assign cfg_o.link_cost = link_cost_q;

endmodule

// File: rtl/core/dvr_datapath.sv
`timescale 1ns / 1ps

module dvr_datapath (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  dvr_pkg::dvr_cfg_t             cfg_i,
  input  dvr_pkg::dvr_cmd_t             cmd_i,
  input  logic [dvr_pkg::IN_DATA_W-1:0] in_data_i,
  input  logic                          in_op_i,
  output logic [dvr_pkg::OUT_DATA_W-1:0] out_data_o
);

  localparam int DW = dvr_pkg::DIST_W;
  localparam int HW = dvr_pkg::HOP_W;
  localparam int EW = dvr_pkg::ENTRY_W;

  logic [dvr_pkg::NODE_COUNT-1:0][DW-1:0] dist_q, dist_d;
  logic [dvr_pkg::NODE_COUNT-1:0][HW-1:0] hop_q, hop_d;
  logic [dvr_pkg::NODE_COUNT-1:0]         upd;
  logic                                   changed_q, changed_d;
  logic                                   rejected_q, rejected_d;
  logic [EW-1:0]                          sender;
  logic [DW-1:0]                          cost;
  logic                                   reject;

  assign sender = in_data_i[EW-1:0];

  // cost of the link to the sender; out-of-range sender reads as no link
  always_comb begin
    cost = dvr_pkg::DIST_NONE;
    for (int j = 0; j < dvr_pkg::NODE_COUNT; j++) begin
      if (sender == EW'(j)) begin
        cost = cfg_i.link_cost[j];
      end
    end
  end

  assign reject = cost[DW-1];

  for (genvar i = 0; i < dvr_pkg::NODE_COUNT; i++) begin : g_entry
    logic [DW-1:0] d_in;
    logic [DW:0]   sum;
    logic [DW-1:0] sat;
    logic [DW-1:0] lc;

    assign d_in = in_data_i[EW + DW*i +: DW];
    assign lc   = cfg_i.link_cost[i];
    assign sum  = {1'b0, d_in} + {1'b0, cost};
    assign sat  = (sum[DW] || sum[DW-1]) ? dvr_pkg::DIST_MAX : sum[DW-1:0];

    always_comb begin
      dist_d[i] = dist_q[i];
      hop_d[i]  = hop_q[i];
      upd[i]    = 1'b0;
      if (in_op_i == dvr_pkg::OP_INIT) begin
        dist_d[i] = lc[DW-1] ? dvr_pkg::DIST_NONE : lc;
        hop_d[i]  = lc[DW-1] ? dvr_pkg::HOP_NONE : HW'(i);
        upd[i]    = (dist_d[i] != dist_q[i]) || (hop_d[i] != hop_q[i]);
      end else if (!reject && (cfg_i.my_node != EW'(i)) && !d_in[DW-1]) begin
        // stored distances are either unreachable or non-negative
        if (dist_q[i][DW-1] || (sat < dist_q[i])) begin
          dist_d[i] = sat;
          hop_d[i]  = {1'b0, sender};
          upd[i]    = 1'b1;
        end
      end
    end
  end

  assign changed_d  = |upd;
  assign rejected_d = (in_op_i == dvr_pkg::OP_APPLY) && reject;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < dvr_pkg::NODE_COUNT; i++) begin
        dist_q[i] <= dvr_pkg::DIST_NONE;
        hop_q[i]  <= dvr_pkg::HOP_NONE;
      end
      changed_q  <= 1'b0;
      rejected_q <= 1'b0;
    end else if (cmd_i.load) begin
      dist_q     <= dist_d;
      hop_q      <= hop_d;
      changed_q  <= changed_d;
      rejected_q <= rejected_d;
    end
  end

  logic [DW-1:0] rd_dist;
  logic [HW-1:0] rd_hop;

  always_comb begin
    rd_dist = dist_q[0];
    rd_hop  = hop_q[0];
    for (int i = 0; i < dvr_pkg::NODE_COUNT; i++) begin
      if (cmd_i.idx == EW'(i)) begin
        rd_dist = dist_q[i];
        rd_hop  = hop_q[i];
      end
    end
  end

  assign out_data_o = {7'b0, rejected_q, changed_q, rd_hop, rd_dist, cmd_i.idx};

endmodule

// File: rtl/core/dvr_ctrl.sv
`timescale 1ns / 1ps

module dvr_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic              out_last_o,
  output dvr_pkg::dvr_cmd_t cmd_o
);

  typedef enum logic {
    ST_IDLE,
    ST_EMIT
  } state_e;

  state_e                      state_q;
  logic [dvr_pkg::ENTRY_W-1:0] cnt_q;
  logic                        accept;
  logic                        beat;
  logic                        at_last;

  assign at_last     = cnt_q == dvr_pkg::ENTRY_W'(dvr_pkg::NODE_COUNT - 1);
  assign out_valid_o = state_q == ST_EMIT;
  assign out_last_o  = out_valid_o && at_last;
  assign beat        = out_valid_o && out_ready_i;
  // take the next item in the cycle the last beat leaves
  assign in_ready_o  = (state_q == ST_IDLE) || (beat && at_last);
  assign accept      = in_valid_i && in_ready_o;

  assign cmd_o.load = accept;
  assign cmd_o.idx  = cnt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
    end else begin
      case (state_q)
        ST_IDLE: begin
          if (accept) begin
            state_q <= ST_EMIT;
            cnt_q   <= '0;
          end
        end
        ST_EMIT: begin
          if (beat) begin
            if (at_last) begin
              cnt_q   <= '0;
              state_q <= accept ? ST_EMIT : ST_IDLE;
            end else begin
              cnt_q <= cnt_q + 1'b1;
            end
          end
        end
        default: begin
          state_q <= ST_IDLE;
          cnt_q   <= '0;
        end
      endcase
    end
  end

`ifndef NO_ASSERTIONS
  a_accept_starts_dump : assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> (out_valid_o && cnt_q == '0))
    else $error("accepted item did not start a dump at entry zero");

  a_no_accept_mid_dump : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !(beat && at_last)) |-> !in_ready_o)
    else $error("input ready while a dump is still running");

  a_stall_holds_index : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=> (out_valid_o && $stable(cnt_q)))
    else $error("entry index moved during an output stall");

  a_cnt_in_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= dvr_pkg::ENTRY_W'(dvr_pkg::NODE_COUNT - 1))
    else $error("entry counter beyond last node");
`endif

endmodule

// File: rtl/core/distance_vector_route_update_core.sv
`timescale 1ns / 1ps
// Channel   Dir  Handshake                     Payload
// s_axis    in   s_axis_tvalid/s_axis_tready   tdata: sender, dist_0..dist_5; tuser: operation
// m_axis    out  m_axis_tvalid/m_axis_tready   tdata: entry, distance, next hop, changed,
//                                              rejected; tlast: last entry
// apb       in   psel/penable/pwrite, pready=1 my_node @0x00, link_cost_i @0x04+4*i
//
// Each item is handled as a six-entry dump through the single output port:
// the table updates at acceptance and one beat per node entry follows, the first one later.
// The next item is taken in the cycle the last beat of the previous dump leaves.
// Reset clears the route table to unreachable / no hop and the registers to their defaults.
// A stall on m_axis holds the current entry and blocks further input.

module distance_vector_route_update_core (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  // [2:0] sender, [18:3] dist_0, [34:19] dist_1, [50:35] dist_2, [66:51] dist_3,
  // [82:67] dist_4, [98:83] dist_5, [103:99] zero
  input  logic [dvr_pkg::IN_DATA_W-1:0]  s_axis_tdata,
  // [0] operation
  input  logic                           s_axis_tuser,
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // [2:0] entry_index, [18:3] route_distance_out, [22:19] next_hop_out,
  // [23] table_changed, [24] rejected, [31:25] zero
  output logic [dvr_pkg::OUT_DATA_W-1:0] m_axis_tdata,
  output logic                           m_axis_tlast,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [dvr_pkg::ADDR_W-1:0]     paddr,
  input  logic [31:0]                    pwdata,
  output logic [31:0]                    prdata,
  output logic                           pready
);

  dvr_pkg::dvr_cfg_t cfg;
  dvr_pkg::dvr_cmd_t cmd;

  dvr_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  dvr_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_last_o  (m_axis_tlast),
    .cmd_o       (cmd)
  );

  dvr_datapath u_datapath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg),
    .cmd_i      (cmd),
    .in_data_i  (s_axis_tdata),
    .in_op_i    (s_axis_tuser),
    .out_data_o (m_axis_tdata)
  );

endmodule
